/* rtl/core/rbid_pkg.sv */
// shared types and constants of the run-length icon decoder
`default_nettype none
package rbid_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned CoordW  = 9;
  localparam int unsigned ColorW  = 4;
  localparam int unsigned CountW  = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // body byte layout
  localparam int unsigned RunFlagBit = 7;
  localparam int unsigned RunOnBit   = 6;
  localparam logic [CountW-1:0] LitPixels = CountW'(7);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOriginColumn = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOriginRow    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInkColor     = 2'd2;

  localparam logic [ColorW-1:0] InkColorReset = 4'd1;

  typedef enum logic [2:0] {
    S_WAIT,
    S_HEIGHT,
    S_BUDGET,
    S_BODY,
    S_DONE,
    S_HALT,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic load_width;
    logic load_height;
    logic load_budget;
    logic begin_byte;
    logic step;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic empty_img;
    logic budget_zero;
    logic run_zero_in;
    logic step_last;
    logic step_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/rbid_in_if.sv */
// code byte request channel
`default_nettype none
interface rbid_in_if;
  logic                       valid;
  logic                       ready;
  logic [rbid_pkg::CodeW-1:0] code_byte;
  logic                       start_req;

  modport source (output valid, output code_byte, output start_req, input ready);
  modport sink (input valid, input code_byte, input start_req, output ready);
endinterface
`default_nettype wire

/* rtl/core/rbid_out_if.sv */
// pixel result request channel
`default_nettype none
interface rbid_out_if;
  logic                        valid;
  logic                        ready;
  logic [rbid_pkg::CoordW-1:0] pixel_column;
  logic [rbid_pkg::CoordW-1:0] pixel_row;
  logic                        pixel_on;
  logic [rbid_pkg::ColorW-1:0] color;
  logic                        last_of_item;
  logic                        image_done;
  logic                        encoding_error;

  modport source (output valid, output pixel_column, output pixel_row, output pixel_on,
                  output color, output last_of_item, output image_done,
                  output encoding_error, input ready);
  modport sink (input valid, input pixel_column, input pixel_row, input pixel_on,
                input color, input last_of_item, input image_done,
                input encoding_error, output ready);
endinterface
`default_nettype wire

/* rtl/core/rbid_ctrl.sv */
// decoder controller state machine
`default_nettype none
module rbid_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              start_req,
  input  wire rbid_pkg::status_t status,
  output logic                   in_ready,
  output rbid_pkg::cmd_t         cmd
);

  rbid_pkg::state_t state;
  rbid_pkg::state_t state_next;
  logic             fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbid_pkg::S_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    fire       = 1'b0;
    unique case (state)
      rbid_pkg::S_WAIT, rbid_pkg::S_DONE, rbid_pkg::S_HALT: begin
        in_ready = 1'b1;
        fire     = in_valid;
        if (fire && start_req) begin
          cmd.load_width = 1'b1;
          state_next     = rbid_pkg::S_HEIGHT;
        end
      end
      rbid_pkg::S_HEIGHT: begin
        in_ready = 1'b1;
        fire     = in_valid;
        if (fire && start_req) begin
          cmd.load_width = 1'b1;
        end else if (fire) begin
          cmd.load_height = 1'b1;
          state_next      = rbid_pkg::S_BUDGET;
        end
      end
      rbid_pkg::S_BUDGET: begin
        in_ready = 1'b1;
        fire     = in_valid;
        if (fire && start_req) begin
          cmd.load_width = 1'b1;
          state_next     = rbid_pkg::S_HEIGHT;
        end else if (fire) begin
          cmd.load_budget = 1'b1;
          state_next = status.empty_img ? rbid_pkg::S_DONE : rbid_pkg::S_BODY;
        end
      end
      rbid_pkg::S_BODY: begin
        in_ready = 1'b1;
        fire     = in_valid;
        if (fire && start_req) begin
          cmd.load_width = 1'b1;
          state_next     = rbid_pkg::S_HEIGHT;
        end else if (fire && status.budget_zero) begin
          state_next = rbid_pkg::S_ERR;
        end else if (fire) begin
          cmd.begin_byte = 1'b1;
          state_next = status.run_zero_in ? rbid_pkg::S_BODY : rbid_pkg::S_EMIT;
        end
      end
      rbid_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.step_done) begin
            state_next = rbid_pkg::S_DONE;
          end else if (status.step_last) begin
            state_next = rbid_pkg::S_BODY;
          end
        end
      end
      rbid_pkg::S_ERR: begin
        if (status.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = rbid_pkg::S_HALT;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/rbid_datapath.sv */
// configuration, header, budget, pixel position and result registers
`default_nettype none
module rbid_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rbid_pkg::CodeW-1:0]    code_byte,
  input  wire logic                          write_en,
  input  wire logic [rbid_pkg::CfgIdxW-1:0]  write_index,
  input  wire logic [rbid_pkg::CfgDataW-1:0] write_data,
  input  wire rbid_pkg::cmd_t                cmd,
  output rbid_pkg::status_t                  status,
  rbid_out_if.source                         pixels
);

  logic [7:0]                    origin_column;
  logic [7:0]                    origin_row;
  logic [rbid_pkg::ColorW-1:0]   ink_color;

  logic [7:0]                    icon_width;
  logic [7:0]                    icon_height;
  logic [7:0]                    bytes_left;
  logic [7:0]                    column_index;
  logic [7:0]                    row_index;
  logic [rbid_pkg::CodeW-1:0]    bits;
  logic                          is_run;
  logic                          run_on;
  logic [rbid_pkg::CountW-1:0]   count;

  logic [7:0] row_inc;
  logic [7:0] col_inc;
  logic       col_end;
  logic       cur_on;

  assign row_inc = row_index + 8'd1;
  assign col_inc = column_index + 8'd1;
  assign col_end = (row_inc == icon_height);
  assign cur_on  = is_run ? run_on : bits[0];

  assign status.empty_img   = (icon_width == '0) || (icon_height == '0);
  assign status.budget_zero = (bytes_left == '0);
  assign status.run_zero_in = code_byte[rbid_pkg::RunFlagBit] &&
                              (code_byte[rbid_pkg::CountW-1:0] == '0);
  assign status.step_last   = (count == rbid_pkg::CountW'(1));
  assign status.step_done   = col_end && (col_inc == icon_width);
  assign status.out_free    = !pixels.valid || pixels.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_column <= '0;
      origin_row    <= '0;
      ink_color     <= rbid_pkg::InkColorReset;
    end else if (write_en) begin
      unique case (write_index)
        rbid_pkg::CfgOriginColumn: origin_column <= write_data;
        rbid_pkg::CfgOriginRow:    origin_row    <= write_data;
        rbid_pkg::CfgInkColor:     ink_color     <= write_data[rbid_pkg::ColorW-1:0];
        default: ;
      endcase
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      icon_width   <= '0;
      icon_height  <= '0;
      bytes_left   <= '0;
      column_index <= '0;
      row_index    <= '0;
    end else begin
      if (cmd.load_width) begin
        icon_width   <= code_byte;
        icon_height  <= '0;
        bytes_left   <= '0;
        column_index <= '0;
        row_index    <= '0;
      end
      if (cmd.load_height) begin
        icon_height <= code_byte;
      end
      if (cmd.load_budget) begin
        bytes_left <= code_byte;
      end
      if (cmd.begin_byte) begin
        bytes_left <= bytes_left - 8'd1;
      end
      if (cmd.step) begin
        if (col_end) begin
          row_index    <= '0;
          column_index <= col_inc;
        end else begin
          row_index <= row_inc;
        end
      end
    end
  end

  // current body byte
  always_ff @(posedge clk) begin
    if (cmd.begin_byte) begin
      bits   <= code_byte;
      is_run <= code_byte[rbid_pkg::RunFlagBit];
      run_on <= code_byte[rbid_pkg::RunOnBit];
      count  <= code_byte[rbid_pkg::RunFlagBit] ? code_byte[rbid_pkg::CountW-1:0]
                                                : rbid_pkg::LitPixels;
    end else if (cmd.step) begin
      bits  <= bits >> 1;
      count <= count - rbid_pkg::CountW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (cmd.step || cmd.emit_err) begin
      pixels.valid <= 1'b1;
    end else if (pixels.ready) begin
      pixels.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixels.pixel_column   <= {1'b0, origin_column} + {1'b0, column_index};
      pixels.pixel_row      <= {1'b0, origin_row} + {1'b0, row_index};
      pixels.pixel_on       <= cur_on;
      pixels.color          <= ink_color;
      pixels.last_of_item   <= status.step_last || status.step_done;
      pixels.image_done     <= status.step_done;
      pixels.encoding_error <= 1'b0;
    end else if (cmd.emit_err) begin
      pixels.pixel_column   <= '0;
      pixels.pixel_row      <= '0;
      pixels.pixel_on       <= 1'b0;
      pixels.color          <= '0;
      pixels.last_of_item   <= 1'b1;
      pixels.image_done     <= 1'b0;
      pixels.encoding_error <= 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rle_bitmap_icon_decoder_unit.sv */
// run-length icon decoder: top level joining controller and datapath
// intake: a header byte is taken in its header state; a body byte is registered and its
//   first pixel reaches the result channel in the cycle after its first emit step
// throughput: one pixel per cycle while the result channel is free; a literal byte gives
//   7 pixels, a run byte up to 63; the emit loop sets the rate and takes no byte meanwhile
// reset: rst clears the controller to waiting for start, the result channel to empty
//   and origin_column, origin_row and ink_color to 0, 0 and 1
`default_nettype none
module rle_bitmap_icon_decoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration writes
  input  wire logic                          write_en,
  input  wire logic [rbid_pkg::CfgIdxW-1:0]  write_index,
  input  wire logic [rbid_pkg::CfgDataW-1:0] write_data,
  // encoded byte requests in, pixel requests out
  rbid_in_if.sink                            codes,
  rbid_out_if.source                         pixels
);

  rbid_pkg::cmd_t    cmd;
  rbid_pkg::status_t status;

  // controller: header phases, body byte dispatch, per-pixel emit loop, error result
  rbid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (codes.valid),
    .start_req (codes.start_req),
    .status    (status),
    .in_ready  (codes.ready),
    .cmd       (cmd)
  );

  // datapath: config, header, budget, position counters and the result register
  // the result register parts the channels, so header bytes pass while a pixel waits
  rbid_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .code_byte   (codes.code_byte),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .cmd         (cmd),
    .status      (status),
    .pixels      (pixels)
  );

endmodule
`default_nettype wire

/* tb/sv/rle_bitmap_icon_decoder_unit_checker.sv */
// checker: tracks decoder state from the byte requests and compares every pixel request
`timescale 1ns / 1ps
module rle_bitmap_icon_decoder_unit_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          write_en,
  input  wire logic [rbid_pkg::CfgIdxW-1:0]  write_index,
  input  wire logic [rbid_pkg::CfgDataW-1:0] write_data,
  rbid_in_if                                 codes,
  rbid_out_if                                pixels,
  output int                                 failures,
  output int                                 outstanding
);

  typedef struct packed {
    logic [rbid_pkg::CoordW-1:0] column;
    logic [rbid_pkg::CoordW-1:0] row;
    logic                        on;
    logic [rbid_pkg::ColorW-1:0] color;
    logic                        last;
    logic                        done;
    logic                        err;
  } pixel_t;

  pixel_t pixel_q[$];

  // own copy of the registers and of the decoder state
  logic [7:0]                  origin_col;
  logic [7:0]                  origin_row;
  logic [rbid_pkg::ColorW-1:0] ink;
  rbid_pkg::state_t            dec_phase;
  logic [7:0]                  width_r;
  logic [7:0]                  height_r;
  logic [7:0]                  budget_r;
  logic [7:0]                  col_r;
  logic [7:0]                  row_r;

  // expected pixels of one accepted byte, appended to pixel_q
  task automatic decode_byte(input logic [7:0] b, input logic s);
    pixel_t held;
    logic   have;
    logic   finished;
    int     count;
    int     k;
    logic   on;
    held     = '0;
    have     = 1'b0;
    finished = 1'b0;
    if (s) begin
      width_r   = b;
      height_r  = '0;
      budget_r  = '0;
      col_r     = '0;
      row_r     = '0;
      dec_phase = rbid_pkg::S_HEIGHT;
    end else begin
      case (dec_phase)
        rbid_pkg::S_HEIGHT: begin
          height_r  = b;
          dec_phase = rbid_pkg::S_BUDGET;
        end
        rbid_pkg::S_BUDGET: begin
          budget_r  = b;
          dec_phase = (width_r == 8'd0 || height_r == 8'd0) ? rbid_pkg::S_DONE
                                                             : rbid_pkg::S_BODY;
        end
        rbid_pkg::S_BODY: begin
          if (budget_r == 8'd0) begin
            // budget exhausted with pixels still owed
            held.last = 1'b1;
            held.err  = 1'b1;
            pixel_q.push_back(held);
            dec_phase = rbid_pkg::S_HALT;
          end else begin
            budget_r = budget_r - 8'd1;
            count = b[rbid_pkg::RunFlagBit] ? int'(b[rbid_pkg::CountW-1:0])
                                            : int'(rbid_pkg::LitPixels);
            for (k = 0; k < count && !finished; k++) begin
              on = b[rbid_pkg::RunFlagBit] ? b[rbid_pkg::RunOnBit] : b[k];
              if (have) pixel_q.push_back(held);
              held.column = {1'b0, origin_col} + {1'b0, col_r};
              held.row    = {1'b0, origin_row} + {1'b0, row_r};
              held.on     = on;
              held.color  = ink;
              held.last   = 1'b0;
              held.done   = 1'b0;
              held.err    = 1'b0;
              have        = 1'b1;
              row_r = row_r + 8'd1;
              if (row_r == height_r) begin
                row_r = '0;
                col_r = col_r + 8'd1;
                if (col_r == width_r) begin
                  finished  = 1'b1;
                  held.done = 1'b1;
                end
              end
            end
            if (have) begin
              held.last = 1'b1;
              pixel_q.push_back(held);
            end
            if (finished) dec_phase = rbid_pkg::S_DONE;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures = failures + 1;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      origin_col = '0;
      origin_row = '0;
      ink        = rbid_pkg::InkColorReset;
      dec_phase  = rbid_pkg::S_WAIT;
      width_r    = '0;
      height_r   = '0;
      budget_r   = '0;
      col_r      = '0;
      row_r      = '0;
      pixel_q.delete();
    end else begin
      if (write_en) begin
        case (write_index)
          rbid_pkg::CfgOriginColumn: origin_col = write_data;
          rbid_pkg::CfgOriginRow:    origin_row = write_data;
          rbid_pkg::CfgInkColor:     ink = write_data[rbid_pkg::ColorW-1:0];
          default: ;
        endcase
      end
      if (codes.valid && codes.ready) decode_byte(codes.code_byte, codes.start_req);
      if (pixels.valid && pixels.ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel request: column %0d row %0d error %0d",
                 pixels.pixel_column, pixels.pixel_row, pixels.encoding_error);
          failures = failures + 1;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_column", want.column, pixels.pixel_column);
          check_field("pixel_row", want.row, pixels.pixel_row);
          check_field("pixel_on", want.on, pixels.pixel_on);
          check_field("color", want.color, pixels.color);
          check_field("last_of_item", want.last, pixels.last_of_item);
          check_field("image_done", want.done, pixels.image_done);
          check_field("encoding_error", want.err, pixels.encoding_error);
        end
      end
    end
    outstanding <= pixel_q.size();
  end

endmodule

/* tb/sv/rle_bitmap_icon_decoder_unit_test.sv */
// testbench top: byte stimulus, pixel back-pressure and the verdict
`timescale 1ns / 1ps
module rle_bitmap_icon_decoder_unit_test;

  localparam int LIMIT        = 400000; // cycles before the run is called hung
  localparam int SETTLE       = 100;    // longer than the slowest byte, a run of 63 pixels
  localparam int LONG_HOLD    = 300;    // long receiver hold-off
  localparam int RANDOM_ITEMS = 100;
  localparam int PHASES       = 4;

  logic                          clk;
  logic                          rst;
  logic                          write_en;
  logic [rbid_pkg::CfgIdxW-1:0]  write_index;
  logic [rbid_pkg::CfgDataW-1:0] write_data;

  int failures;
  int outstanding;
  int cycles;
  int burst_left;
  int random_items;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int tick;
  int stall_mode;

  rbid_in_if  codes_if ();
  rbid_out_if pixels_if ();

  rle_bitmap_icon_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .codes       (codes_if),
    .pixels      (pixels_if)
  );

  rle_bitmap_icon_decoder_unit_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .codes       (codes_if),
    .pixels      (pixels_if),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    clk <= 1'b0;
    #5;
    clk <= 1'b1;
    #5;
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("rle_bitmap_icon_decoder_unit test failed");
      $finish;
    end
  end

  // pixel receiver: stall pattern picked at random from four modes, long hold-off on request
  initial begin
    pixels_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick = tick + 1;
      if (tick % 50 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        pixels_if.ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
        // long hold-off so the decoder backs up and stalls the byte requests
        hold_seen = hold_asks;
        hold_left = LONG_HOLD - 1;
        pixels_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       pixels_if.ready <= 1'b1;
          1:       pixels_if.ready <= 1'($urandom_range(0, 1));
          2:       pixels_if.ready <= ($urandom_range(0, 7) != 0);
          default: pixels_if.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // one byte request; bursts of random length with random gaps in between
  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        codes_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    codes_if.valid     <= 1'b1;
    codes_if.code_byte <= b;
    codes_if.start_req <= s;
    @(posedge clk);
    while (!codes_if.ready) @(posedge clk);
    burst_left = burst_left - 1;
  endtask

  // sender pauses until every expected pixel is back, then lets the decoder settle
  task automatic drain_results();
    codes_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // only called while the decoder is idle
  task automatic configure(input logic [7:0] col, input logic [7:0] row,
                           input logic [rbid_pkg::ColorW-1:0] ink);
    write_en    <= 1'b1;
    write_index <= rbid_pkg::CfgOriginColumn;
    write_data  <= col;
    @(posedge clk);
    write_index <= rbid_pkg::CfgOriginRow;
    write_data  <= row;
    @(posedge clk);
    write_index <= rbid_pkg::CfgInkColor;
    write_data  <= {4'b0, ink};
    @(posedge clk);
    write_en <= 1'b0;
  endtask

  function automatic logic [7:0] random_body_byte();
    logic [5:0] count;
    if ($urandom_range(0, 1) == 0) return {1'b0, 7'($urandom_range(0, 127))};
    // mostly short runs, now and then up to the full 63
    count = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 12));
    return {1'b1, 1'($urandom_range(0, 1)), count};
  endfunction

  // one random image; settled is low when it was cut short by a restart
  task automatic run_random_image(output logic settled);
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] budget;
    logic [7:0] b;
    logic [7:0] body[$];
    int         total;
    int         covered;
    int         style;
    int         cut;
    int         sent;
    int         k;
    w = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 12)) : 8'($urandom_range(1, 4));
    h = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(20, 63)) : 8'($urandom_range(1, 8));
    // now and then an empty image
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 0) w = 8'd0;
      else h = 8'd0;
    end
    total   = int'(w) * int'(h);
    covered = 0;
    while (covered < total && body.size() < 255) begin
      b = random_body_byte();
      body.push_back(b);
      covered += b[rbid_pkg::RunFlagBit] ? int'(b[rbid_pkg::CountW-1:0])
                                         : int'(rbid_pkg::LitPixels);
    end
    style  = $urandom_range(0, 19);
    budget = 8'(body.size());
    if (style < 3 && body.size() > 0) begin
      // short budget: error request, rest of the body ignored while halted
      budget = 8'($urandom_range(0, body.size() - 1));
    end else if (style < 5) begin
      budget = (body.size() + 20 > 255) ? 8'd255 : 8'(body.size() + $urandom_range(1, 20));
    end
    cut     = (style == 19) ? $urandom_range(1, body.size() + 2) : body.size() + 3;
    settled = (style != 19);
    sent    = 0;
    send_byte(w, 1'b1);
    sent++;
    if (sent < cut) begin
      send_byte(h, 1'b0);
      sent++;
    end
    if (sent < cut) begin
      send_byte(budget, 1'b0);
      sent++;
    end
    for (k = 0; k < body.size() && sent < cut; k++) begin
      send_byte(body[k], 1'b0);
      sent++;
    end
    random_items += sent;
    // trailing bytes after completion are ignored
    if (settled && style >= 5 && style < 8) begin
      repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    logic settled;
    int   ph;
    rst                <= 1'b1;
    write_en           <= 1'b0;
    write_index        <= rbid_pkg::CfgOriginColumn;
    write_data         <= '0;
    codes_if.valid     <= 1'b0;
    codes_if.code_byte <= '0;
    codes_if.start_req <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset register values first
    // byte before any start: ignored
    send_byte(8'hFF, 1'b0);
    // 2 x 3 image, literal carries 7 pixels so the last one is dropped
    send_byte(8'd2, 1'b1);
    send_byte(8'd3, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'h55, 1'b0);
    // after completion: ignored
    send_byte(8'h81, 1'b0);
    drain_results();

    // largest origins and ink
    configure(8'hFF, 8'hFF, 4'hF);
    // empty image, height zero, later body byte ignored
    send_byte(8'd1, 1'b1);
    send_byte(8'd0, 1'b0);
    send_byte(8'd5, 1'b0);
    send_byte(8'hC5, 1'b0);
    // full runs on and off around a zero run, then budget runs out, then halted
    send_byte(8'd1, 1'b1);
    send_byte(8'd130, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // widest header, restarted in the middle of the body
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    // restart during the header, zero budget gives the error at once
    send_byte(8'd9, 1'b1);
    send_byte(8'd1, 1'b1);
    send_byte(8'd1, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'h2A, 1'b0);
    drain_results();

    // random part over several register settings
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       configure(8'h00, 8'h00, 4'h0);
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           4'($urandom_range(0, 15)));
      endcase
      // one phase opens with the receiver held off while bytes keep coming
      if (ph == 2) hold_asks = hold_asks + 1;
      settled = 1'b0;
      while (random_items < (ph + 1) * RANDOM_ITEMS / PHASES || !settled)
        run_random_image(settled);
      drain_results();
    end

    if (failures == 0 && outstanding == 0) begin
      $display("rle_bitmap_icon_decoder_unit test passed");
    end else begin
      $display("rle_bitmap_icon_decoder_unit test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rbid_pkg.sv
rtl/core/rbid_in_if.sv
rtl/core/rbid_out_if.sv
rtl/core/rbid_ctrl.sv
rtl/core/rbid_datapath.sv
rtl/core/rle_bitmap_icon_decoder_unit.sv
tb/sv/rle_bitmap_icon_decoder_unit_checker.sv
tb/sv/rle_bitmap_icon_decoder_unit_test.sv
